[rtl/mvrm_pkg.sv]
// Shared types, constants and defaults for the multi-voice resampling mixer.
`timescale 1ns / 1ps
package mvrm_pkg;

	localparam int DEF_VOICES      = 16;
	localparam int DEF_FIFO_FRAMES = 4096;
	localparam int DEF_OUTPUT_RATE = 44100;

	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 17;
	localparam int GAIN_W   = 17;
	localparam int STEP_W   = 18;
	localparam int FRAC_W   = 16;
	// Dividend of the step division: rate shifted left by the fraction width
	localparam int NUM_W    = RATE_W + FRAC_W;

	localparam logic [STEP_W-1:0] STEP_MAX     = 18'h3FFFF;
	localparam logic [STEP_W-1:0] STEP_UNITY   = 18'd65536;
	localparam logic [GAIN_W-1:0] GAIN_UNITY   = 17'd65536;
	localparam logic [RATE_W-1:0] RATE_DEFAULT = 17'd44100;
	localparam logic [FRAC_W-1:0] FRAC_MASK    = 16'hFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_FORMAT = 3'd1,
		OP_GAIN   = 3'd2,
		OP_PLAY   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_TICK   = 3'd5
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [3:0]                 voice;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [RATE_W-1:0]          rate;
		logic                       mono;
		logic [GAIN_W-1:0]          gain;
		logic                       playing;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_VSEL,
		ST_RDNX,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_OUT
	} state_t;

endpackage

[rtl/mvrm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module mvrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/mvrm_front.sv]
// Front end: accepts input items, drops items with an unknown operation or an out-of-range voice, and queues commands.
`timescale 1ns / 1ps
module mvrm_front #(
	parameter int VOICES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  operation,
	input  logic [3:0]                  voice,
	input  logic signed [15:0]          left_in,
	input  logic signed [15:0]          right_in,
	input  logic [16:0]                 source_rate,
	input  logic                        mono,
	input  logic [16:0]                 gain,
	input  logic                        playing,
	output logic                        deq_valid,
	input  logic                        deq_ready,
	output mvrm_pkg::cmd_t              deq_cmd
);
	import mvrm_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push_en;
	logic       pop_en;
	cmd_t       cmd;

	// Classify: keep ticks and in-range voice commands
	always_comb begin
		cmd.op      = op_t'(operation);
		cmd.voice   = voice;
		cmd.left    = left_in;
		cmd.right   = right_in;
		cmd.rate    = source_rate;
		cmd.mono    = mono;
		cmd.gain    = gain;
		cmd.playing = playing;
		unique case (operation)
			OP_TICK: keep = 1'b1;
			OP_PUSH, OP_FORMAT, OP_GAIN, OP_PLAY, OP_CLEAR:
				keep = ({3'b000, voice} < 7'(VOICES));
			default: keep = 1'b0;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push_en   = in_valid && in_ready && keep;
	assign deq_valid = (cnt_q != 2'd0);
	assign pop_en    = deq_valid && deq_ready;
	assign deq_cmd   = mem_q[rptr_q];

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push_en) begin
				wptr_q <= ~wptr_q;
			end
			if (pop_en) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push_en} - {1'b0, pop_en};
		end
	end

	// Store queued command
	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[wptr_q] <= cmd;
		end
	end

endmodule

[rtl/mvrm_back.sv]
// Back end: voice state, frame store access, resampling, mixing and output register.
`timescale 1ns / 1ps
module mvrm_back #(
	parameter int VOICES      = 16,
	parameter int FIFO_FRAMES = 4096,
	parameter int OUTPUT_RATE = 44100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 deq_valid,
	output logic                 deq_ready,
	input  mvrm_pkg::cmd_t       deq_cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   left_out,
	output logic signed [15:0]   right_out
);
	import mvrm_pkg::*;

	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SPAN  = 2 * FIFO_FRAMES;
	localparam int IW    = $clog2(SPAN);
	localparam int OW    = $clog2(FIFO_FRAMES);
	localparam int DEPTH = VOICES * FIFO_FRAMES;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(OUTPUT_RATE + 1);
	localparam int ACC_W = 19 + VW;

	// Reciprocal of the output rate, scaled so the estimate is at most one low
	localparam int     RECIP_SH = NUM_W + 1;
	localparam longint RECIP    = (64'sd1 << RECIP_SH) / OUTPUT_RATE;
	localparam int     RECIP_W  = $clog2(RECIP + 1);
	localparam int     PROD_W   = RATE_W + RECIP_W;
	localparam int     RSH      = RECIP_SH - FRAC_W;
	localparam int     Q_W      = PROD_W - RSH;
	localparam int     QX_W     = (Q_W > STEP_W) ? Q_W : STEP_W + 1;

	state_t state_q, state_d;

	// Per-voice state
	logic [IW-1:0]     wr_q    [VOICES];
	logic [IW-1:0]     rd_q    [VOICES];
	logic [FRAC_W-1:0] frac_q  [VOICES];
	logic [STEP_W-1:0] step_q  [VOICES];
	logic [GAIN_W-1:0] gain_q  [VOICES];
	logic              mono_q  [VOICES];
	logic              play_q  [VOICES];

	// Sequencer registers
	logic [VW-1:0]     k_q;
	logic              has2_q;
	logic [31:0]       cur_q;
	logic signed [33:0] pl_s1, pr_s1;
	logic signed [34:0] pl_s2, pr_s2;
	logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
	logic [NUM_W-1:0]  num_q;
	logic [PROD_W-1:0] prod_q;
	logic [QX_W-1:0]   qe_q;
	logic [NUM_W-1:0]  dprod_q;
	logic [1:0]        dcnt_q;
	logic [VW-1:0]     dv_q;

	// Selected voice view
	logic [6:0]        voice_ext;
	logic [VW-1:0]     sidx;
	logic [IW-1:0]     s_wr, s_rd;
	logic [IW:0]       cnt_ext;
	logic [IW-1:0]     s_cnt;
	logic [AW-1:0]     vbase;
	logic [OW-1:0]     rd_off, nx_off, wr_off;
	logic [IW-1:0]     wr_next;
	logic              last_k;

	// RAM signals
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [31:0]       ram_wdata, ram_rdata;

	// Datapath terms
	logic [31:0]        nxt;
	logic signed [16:0] dl, dr, il, ir;
	logic signed [34:0] tl, tr;
	logic [18:0]        pos;
	logic [2:0]         passed;
	logic [IW-1:0]      psat;
	logic [IW:0]        rd_sum;
	logic [IW-1:0]      rd_new;
	logic [QX_W-1:0]    qe_w;
	logic [QX_W+RW-1:0] dprod_w;
	logic [NUM_W-1:0]   rem_w;
	logic               ge;
	logic [QX_W-1:0]    qfin;
	logic [STEP_W-1:0]  step_new;
	logic [RATE_W-1:0]  rate_eff;
	logic               active;

	function automatic logic [OW-1:0] fifo_off(input logic [IW-1:0] idx);
		logic [IW-1:0] t;
		t = (idx >= IW'(FIFO_FRAMES)) ? (idx - IW'(FIFO_FRAMES)) : idx;
		return t[OW-1:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
		if (x > ACC_W'(SAMPLE_MAX)) begin
			return SAMPLE_MAX;
		end else if (x < ACC_W'(SAMPLE_MIN)) begin
			return SAMPLE_MIN;
		end else begin
			return x[15:0];
		end
	endfunction

	// Select voice and derive FIFO fill and addresses
	always_comb begin
		voice_ext = {3'b000, deq_cmd.voice};
		sidx      = (state_q == ST_IDLE) ? voice_ext[VW-1:0] : k_q;
		s_wr      = wr_q[sidx];
		s_rd      = rd_q[sidx];
		if (s_wr >= s_rd) begin
			cnt_ext = {1'b0, s_wr} - {1'b0, s_rd};
		end else begin
			cnt_ext = {1'b0, s_wr} + (IW+1)'(SPAN) - {1'b0, s_rd};
		end
		s_cnt   = cnt_ext[IW-1:0];
		vbase   = AW'(sidx) * AW'(FIFO_FRAMES);
		rd_off  = fifo_off(s_rd);
		nx_off  = (rd_off == OW'(FIFO_FRAMES - 1)) ? '0 : rd_off + 1'b1;
		wr_off  = fifo_off(s_wr);
		wr_next = (s_wr == IW'(SPAN - 1)) ? '0 : s_wr + 1'b1;
		last_k  = (k_q == VW'(VOICES - 1));
		active  = play_q[sidx] && (s_cnt != '0);
	end

	// Interpolation, scaling and phase advance terms
	always_comb begin
		nxt = has2_q ? ram_rdata : cur_q;
		dl  = 17'($signed(nxt[15:0])) - 17'($signed(cur_q[15:0]));
		dr  = 17'($signed(nxt[31:16])) - 17'($signed(cur_q[31:16]));
		il  = 17'($signed(cur_q[15:0])) + 17'(pl_s1 >>> 16);
		ir  = 17'($signed(cur_q[31:16])) + 17'(pr_s1 >>> 16);
		tl  = (pl_s2 < 0) ? ((pl_s2 + 35'sd65535) >>> 16) : (pl_s2 >>> 16);
		tr  = (pr_s2 < 0) ? ((pr_s2 + 35'sd65535) >>> 16) : (pr_s2 >>> 16);
		pos    = {3'b000, frac_q[sidx]} + {1'b0, step_q[sidx]};
		passed = pos[18:16];
		psat   = (IW'(passed) > s_cnt) ? s_cnt : IW'(passed);
		rd_sum = {1'b0, s_rd} + {1'b0, psat};
		rd_new = (rd_sum >= (IW+1)'(SPAN)) ? IW'(rd_sum - (IW+1)'(SPAN)) : rd_sum[IW-1:0];
	end

	// Phase step by reciprocal multiply, back multiply and one correction
	always_comb begin
		qe_w     = QX_W'(prod_q[PROD_W-1:RSH]);
		dprod_w  = qe_w * RW'(OUTPUT_RATE);
		rem_w    = num_q - dprod_q;
		ge       = (rem_w >= NUM_W'(OUTPUT_RATE));
		qfin     = qe_q + QX_W'(ge);
		step_new = (qfin > QX_W'(STEP_MAX)) ? STEP_MAX : qfin[STEP_W-1:0];
		rate_eff = (deq_cmd.rate == '0) ? RATE_DEFAULT : deq_cmd.rate;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory control
	always_comb begin
		state_d   = state_q;
		deq_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = vbase + AW'(wr_off);
		ram_wdata = {deq_cmd.left, deq_cmd.left};
		ram_raddr = vbase + AW'(rd_off);
		unique case (state_q)
			ST_IDLE: begin
				deq_ready = 1'b1;
				if (deq_valid) begin
					unique case (deq_cmd.op)
						OP_PUSH: begin
							ram_we    = (s_cnt < IW'(FIFO_FRAMES));
							ram_wdata = mono_q[sidx] ? {deq_cmd.left, deq_cmd.left}
								: {deq_cmd.right, deq_cmd.left};
						end
						OP_FORMAT: state_d = ST_DIV;
						OP_TICK:   state_d = ST_VSEL;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (dcnt_q == 2'd2) begin
					state_d = ST_IDLE;
				end
			end
			ST_VSEL: begin
				if (active) begin
					state_d = ST_RDNX;
				end else if (last_k) begin
					state_d = ST_OUT;
				end
			end
			ST_RDNX: begin
				ram_raddr = vbase + AW'(nx_off);
				state_d   = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ACC;
			ST_ACC:  state_d = last_k ? ST_OUT : ST_VSEL;
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Update voice state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				wr_q[i]   <= '0;
				rd_q[i]   <= '0;
				frac_q[i] <= '0;
				step_q[i] <= STEP_UNITY;
				gain_q[i] <= GAIN_UNITY;
				mono_q[i] <= 1'b0;
				play_q[i] <= 1'b0;
			end
			k_q       <= '0;
			dcnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			// Raise the output on a finished tick, drop it once taken
			if (state_q == ST_OUT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					k_q    <= '0;
					dcnt_q <= '0;
					if (deq_valid) begin
						case (deq_cmd.op)
							OP_PUSH: begin
								if (s_cnt < IW'(FIFO_FRAMES)) begin
									wr_q[sidx] <= wr_next;
								end
							end
							OP_FORMAT: mono_q[sidx] <= deq_cmd.mono;
							OP_GAIN:   gain_q[sidx] <= deq_cmd.gain;
							OP_PLAY:   play_q[sidx] <= deq_cmd.playing;
							OP_CLEAR: begin
								wr_q[sidx]   <= '0;
								rd_q[sidx]   <= '0;
								frac_q[sidx] <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 2'd2) begin
						step_q[dv_q] <= step_new;
					end
				end
				ST_VSEL: begin
					if (!active && !last_k) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_ACC: begin
					frac_q[sidx] <= pos[15:0] & FRAC_MASK;
					rd_q[sidx]   <= rd_new;
					if (!last_k) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_l_q <= '0;
				acc_r_q <= '0;
				num_q   <= {rate_eff, FRAC_W'(0)};
				dv_q    <= voice_ext[VW-1:0];
			end
			ST_DIV: begin
				if (dcnt_q == 2'd0) begin
					prod_q <= num_q[NUM_W-1:FRAC_W] * RECIP_W'(RECIP);
				end
				if (dcnt_q == 2'd1) begin
					qe_q    <= qe_w;
					dprod_q <= NUM_W'(dprod_w);
				end
			end
			ST_VSEL: has2_q <= (s_cnt >= IW'(2));
			ST_RDNX: cur_q <= ram_rdata;
			ST_MUL1: begin
				pl_s1 <= dl * $signed({1'b0, frac_q[sidx]});
				pr_s1 <= dr * $signed({1'b0, frac_q[sidx]});
			end
			ST_MUL2: begin
				pl_s2 <= il * $signed({1'b0, gain_q[sidx]});
				pr_s2 <= ir * $signed({1'b0, gain_q[sidx]});
			end
			ST_ACC: begin
				acc_l_q <= acc_l_q + ACC_W'(tl);
				acc_r_q <= acc_r_q + ACC_W'(tr);
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					left_out  <= sat16(acc_l_q);
					right_out <= sat16(acc_r_q);
				end
			end
			default: ;
		endcase
	end

	mvrm_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_frames (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

[rtl/multi_voice_resampling_mixer.sv]
// Top level of the multi-voice resampling mixer: front queue and back sequencer.
//
//   channel  signals                                        direction
//   input    in_valid/in_ready, operation .. playing        item in
//   output   out_valid/out_ready, left_out, right_out       mix sample out
//
// Push, gain, play and clear are handled in the idle state of the back sequencer.
// Set format runs a reciprocal multiply, a back multiply and a correction.
// An output tick steps through every voice: a stopped or empty voice is only checked, a playing voice
// passes the read, the two multiply stages and the accumulate, as the frame store has a single read port.
// Reset clears all voice state; the frame store needs no clearing pass.
// A two-entry queue takes up to two items while the back is busy or the output stalls.
`timescale 1ns / 1ps
module multi_voice_resampling_mixer #(
	parameter int VOICES      = mvrm_pkg::DEF_VOICES,
	parameter int FIFO_FRAMES = mvrm_pkg::DEF_FIFO_FRAMES,
	parameter int OUTPUT_RATE = mvrm_pkg::DEF_OUTPUT_RATE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic [3:0]         voice,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	input  logic [16:0]        source_rate,
	input  logic               mono,
	input  logic [16:0]        gain,
	input  logic               playing,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out
);
	import mvrm_pkg::*;

	logic deq_valid;
	logic deq_ready;
	cmd_t deq_cmd;

	mvrm_front #(
		.VOICES(VOICES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.voice      (voice),
		.left_in    (left_in),
		.right_in   (right_in),
		.source_rate(source_rate),
		.mono       (mono),
		.gain       (gain),
		.playing    (playing),
		.deq_valid  (deq_valid),
		.deq_ready  (deq_ready),
		.deq_cmd    (deq_cmd)
	);

	mvrm_back #(
		.VOICES     (VOICES),
		.FIFO_FRAMES(FIFO_FRAMES),
		.OUTPUT_RATE(OUTPUT_RATE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.deq_valid(deq_valid),
		.deq_ready(deq_ready),
		.deq_cmd  (deq_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out (left_out),
		.right_out(right_out)
	);

endmodule

[tb/multi_voice_resampling_mixer_tb.sv]
// Self-checking testbench for the multi-voice resampling mixer.
`timescale 1ns / 1ps
module multi_voice_resampling_mixer_tb;
	import mvrm_pkg::*;

	localparam int NV = 16;
	localparam int FF = 4096;
	localparam int ORATE = 44100;
	localparam int SPAN = 2 * FF;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  vc;
		logic [15:0] l;
		logic [15:0] r;
		logic [16:0] rate;
		logic        mn;
		logic [16:0] gn;
		logic        pl;
	} item_t;

	typedef struct packed {
		logic [15:0] l;
		logic [15:0] r;
	} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [3:0] voice = '0;
	logic signed [15:0] left_in = '0;
	logic signed [15:0] right_in = '0;
	logic [16:0] source_rate = '0;
	logic mono = 1'b0;
	logic [16:0] gain = '0;
	logic playing = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;

	multi_voice_resampling_mixer i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .voice(voice), .left_in(left_in), .right_in(right_in),
		.source_rate(source_rate), .mono(mono), .gain(gain), .playing(playing),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_out(left_out), .right_out(right_out)
	);

	always #5 clk = ~clk;

	// Mixer shadow state
	logic [31:0] frames [NV][FF];
	int unsigned wr_idx [NV];
	int unsigned rd_idx [NV];
	int unsigned frac [NV];
	int unsigned step [NV];
	int unsigned vgain [NV];
	bit vmono [NV];
	bit vplay [NV];

	item_t pending_items[$];
	mix_t expected_mix[$];
	int errors = 0;
	int n_ticks = 0;
	int n_mixed = 0;
	longint cycles = 0;
	bit stim_done = 1'b0;

	function automatic longint floor_q16(longint p);
		if (p >= 0) return p >>> 16;
		return -((-p + 65535) >>> 16);
	endfunction

	function automatic longint scale_channel(int a, int b, int unsigned f, int unsigned g);
		longint interp;
		interp = longint'(a) + floor_q16(longint'(b - a) * longint'(f));
		return (interp * longint'(g)) / 65536;
	endfunction

	function automatic logic [15:0] sat16(longint x);
		if (x > 32767) return 16'h7FFF;
		if (x < -32768) return 16'h8000;
		return x[15:0];
	endfunction

	// Apply one transfer to the shadow state, queueing the mix for a tick
	function automatic void mix_apply(item_t it);
		int unsigned cnt, pos, passed;
		logic [31:0] cur, nxt;
		longint suml, sumr;
		longint rate;
		longint st;
		mix_t m;
		if (it.op == OP_TICK) begin
			suml = 0;
			sumr = 0;
			for (int k = 0; k < NV; k++) begin
				if (!vplay[k]) continue;
				cnt = (wr_idx[k] + SPAN - rd_idx[k]) % SPAN;
				if (cnt == 0) continue;
				cur = frames[k][rd_idx[k] % FF];
				nxt = (cnt >= 2) ? frames[k][(rd_idx[k] + 1) % FF] : cur;
				suml += scale_channel(int'($signed(cur[15:0])), int'($signed(nxt[15:0])),
					frac[k], vgain[k]);
				sumr += scale_channel(int'($signed(cur[31:16])), int'($signed(nxt[31:16])),
					frac[k], vgain[k]);
				pos = frac[k] + step[k];
				passed = pos >> 16;
				frac[k] = pos & 16'hFFFF;
				if (passed > cnt) passed = cnt;
				rd_idx[k] = (rd_idx[k] + passed) % SPAN;
			end
			m.l = sat16(suml);
			m.r = sat16(sumr);
			expected_mix.push_back(m);
			return;
		end
		case (it.op)
			OP_PUSH: begin
				cnt = (wr_idx[it.vc] + SPAN - rd_idx[it.vc]) % SPAN;
				if (cnt < FF) begin
					frames[it.vc][wr_idx[it.vc] % FF] = {vmono[it.vc] ? it.l : it.r, it.l};
					wr_idx[it.vc] = (wr_idx[it.vc] + 1) % SPAN;
				end
			end
			OP_FORMAT: begin
				rate = (it.rate == 0) ? 44100 : longint'(it.rate);
				st = (rate * 65536) / ORATE;
				if (st > 'h3FFFF) st = 'h3FFFF;
				step[it.vc] = int'(st);
				vmono[it.vc] = it.mn;
			end
			OP_GAIN: vgain[it.vc] = 32'(it.gn);
			OP_PLAY: vplay[it.vc] = it.pl;
			OP_CLEAR: begin
				wr_idx[it.vc] = 0;
				rd_idx[it.vc] = 0;
				frac[it.vc] = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic item_t make_item(logic [2:0] op, int vc);
		item_t it;
		it.op = op;
		it.vc = vc[3:0];
		it.l = 16'($urandom);
		it.r = 16'($urandom);
		it.rate = 17'($urandom_range(96000, 0));
		if ($urandom_range(9, 0) == 0) it.rate = 17'($urandom);
		it.mn = 1'($urandom);
		it.gn = 17'($urandom_range(65536, 0));
		if ($urandom_range(9, 0) == 0) it.gn = 17'($urandom);
		it.pl = 1'($urandom);
		return it;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(3, 0) != 0) return 0;
		if ($urandom_range(9, 0) == 0) return int'($urandom_range(40, 5));
		return int'($urandom_range(3, 1));
	endfunction

	// Driver: present queued items, with random gaps between transfers
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				mix_apply({operation, voice, left_in, right_in, source_rate, mono, gain, playing});
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (pending_items.size() > 0) begin
					item_t it;
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					{operation, voice, left_in, right_in, source_rate, mono, gain, playing} <= it;
					in_gap <= gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each mix transfer with the oldest prediction
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				mix_t m;
				if (expected_mix.size() == 0) begin
					$display("%0t: unexpected mix output %h %h", $time, left_out, right_out);
					errors++;
				end else begin
					m = expected_mix.pop_front();
					if (m.l !== left_out) begin
						$display("%0t: left_out expected %h actual %h", $time, m.l, left_out);
						errors++;
					end
					if (m.r !== right_out) begin
						$display("%0t: right_out expected %h actual %h", $time, m.r, right_out);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				out_ready <= 1'b1;
				out_gap <= gap_len();
			end
		end
	end

	// Hold a cycle budget for the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		item_t it;
		int vc, r;
		for (int k = 0; k < NV; k++) begin
			wr_idx[k] = 0; rd_idx[k] = 0; frac[k] = 0;
			step[k] = 65536; vgain[k] = 65536; vmono[k] = 0; vplay[k] = 0;
		end

		// Directed: formats at the extremes, gains, mono, clear, underrun, junk codes
		it = make_item(OP_TICK, 0); pending_items.push_back(it);
		it = make_item(OP_FORMAT, 0); it.rate = 0; it.mn = 0; pending_items.push_back(it);
		it = make_item(OP_FORMAT, 1); it.rate = 96000; it.mn = 1; pending_items.push_back(it);
		it = make_item(OP_FORMAT, 2); it.rate = 17'h1FFFF; it.mn = 0; pending_items.push_back(it);
		it = make_item(OP_GAIN, 0); it.gn = 65536; pending_items.push_back(it);
		it = make_item(OP_GAIN, 1); it.gn = 17'h1FFFF; pending_items.push_back(it);
		it = make_item(OP_GAIN, 2); it.gn = 0; pending_items.push_back(it);
		for (int k = 0; k < 3; k++) begin
			it = make_item(OP_PLAY, k); it.pl = 1; pending_items.push_back(it);
		end
		it = make_item(OP_PUSH, 0); it.l = 16'h7FFF; it.r = 16'h8000; pending_items.push_back(it);
		it = make_item(OP_PUSH, 0); it.l = 16'h8000; it.r = 16'h7FFF; pending_items.push_back(it);
		it = make_item(OP_PUSH, 1); it.l = 16'h8000; it.r = 16'h1234; pending_items.push_back(it);
		it = make_item(OP_PUSH, 2); it.l = 16'h7FFF; pending_items.push_back(it);
		it = make_item(OP_TICK, 0); pending_items.push_back(it);
		it = make_item(OP_TICK, 0); pending_items.push_back(it);
		it = make_item(OP_TICK, 0); pending_items.push_back(it);
		it = make_item(3'd6, 0); pending_items.push_back(it);
		it = make_item(3'd7, 0); pending_items.push_back(it);
		it = make_item(OP_CLEAR, 1); pending_items.push_back(it);
		it = make_item(OP_PLAY, 2); it.pl = 0; pending_items.push_back(it);
		it = make_item(OP_TICK, 0); pending_items.push_back(it);

		// Random: mostly pushes and ticks on a few playing voices
		for (int n = 0; n < 1500; n++) begin
			r = int'($urandom_range(99, 0));
			vc = ($urandom_range(3, 0) == 0) ? int'($urandom_range(15, 0))
				: int'($urandom_range(3, 0));
			if (r < 45) it = make_item(OP_PUSH, vc);
			else if (r < 80) it = make_item(OP_TICK, vc);
			else if (r < 86) it = make_item(OP_FORMAT, vc);
			else if (r < 91) it = make_item(OP_GAIN, vc);
			else if (r < 96) begin
				it = make_item(OP_PLAY, vc);
				if ($urandom_range(3, 0) != 0) it.pl = 1;
			end else if (r < 98) it = make_item(OP_CLEAR, vc);
			else it = make_item(3'($urandom_range(7, 6)), vc);
			pending_items.push_back(it);
		end

		foreach (pending_items[i]) if (pending_items[i].op == OP_TICK) n_ticks++;
		n_mixed = pending_items.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for all transfers and predictions, then a short tail
		while (pending_items.size() > 0 || in_valid || expected_mix.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d items including %0d output ticks across all operations",
			n_mixed, n_ticks);
		$display("directed extremes, underrun, mono and clear were exercised");
		if (errors == 0 && expected_mix.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
